// ===== rtl/core/quaternion_vector_rotate_unit_macros.svh =====
// Assertion macros shared by the checker of the quaternion rotation unit.
// Depends on nothing; the user supplies i_clk and i_rst_n in scope.
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define QVR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define QVR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/qvr_pkg.sv =====
// Shared widths, pipeline depths and lane types of the quaternion rotation unit.
// Depends on nothing.
package qvr_pkg;

    localparam int VW       = 16;   // vector / quaternion component width
    localparam int MAG_W    = 51;   // magnitude of one rotated lane, scale 2^-36
    localparam int NUM_W    = 52;   // rounded dividend 2*mag + n
    localparam int DEN2_W   = 34;   // twice the squared norm
    localparam int QB       = 17;   // quotient bits resolved by the divider
    localparam int LAT_PROD = 4;
    localparam int LAT_DIV  = QB + 2;
    localparam int LAT      = LAT_PROD + LAT_DIV;

    // Sign and magnitude of one unscaled rotated component
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_lane;

    // Product pipeline result handed to the dividers
    typedef struct packed {
        t_lane             x;
        t_lane             y;
        t_lane             z;
        logic [DEN2_W-1:0] den2;
        logic              zero;
    } t_prod;

endpackage

// ===== rtl/core/qvr_product.sv =====
// Four-stage exact sandwich product q*(v,0)*conj(q) and squared norm.
// Depends on qvr_pkg.
module qvr_product
    import qvr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [VW-1:0] i_vec_x,
    input  logic signed [VW-1:0] i_vec_y,
    input  logic signed [VW-1:0] i_vec_z,
    input  logic signed [VW-1:0] i_quat_i,
    input  logic signed [VW-1:0] i_quat_j,
    input  logic signed [VW-1:0] i_quat_k,
    input  logic signed [VW-1:0] i_quat_real,
    output t_prod                o_prod
);

    // Stage 1: all 16x16 products
    logic signed [31:0] r_ww, r_ii, r_jj, r_kk, r_dx, r_dy, r_dz;
    logic signed [31:0] r_jvz, r_kvy, r_kvx, r_ivz, r_ivy, r_jvx;
    logic signed [VW-1:0] r1_vx, r1_vy, r1_vz, r1_qi, r1_qj, r1_qk, r1_qw;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww  <= 32'(i_quat_real * i_quat_real);
            r_ii  <= 32'(i_quat_i * i_quat_i);
            r_jj  <= 32'(i_quat_j * i_quat_j);
            r_kk  <= 32'(i_quat_k * i_quat_k);
            r_dx  <= 32'(i_quat_i * i_vec_x);
            r_dy  <= 32'(i_quat_j * i_vec_y);
            r_dz  <= 32'(i_quat_k * i_vec_z);
            r_jvz <= 32'(i_quat_j * i_vec_z);
            r_kvy <= 32'(i_quat_k * i_vec_y);
            r_kvx <= 32'(i_quat_k * i_vec_x);
            r_ivz <= 32'(i_quat_i * i_vec_z);
            r_ivy <= 32'(i_quat_i * i_vec_y);
            r_jvx <= 32'(i_quat_j * i_vec_x);
            r1_vx <= i_vec_x;
            r1_vy <= i_vec_y;
            r1_vz <= i_vec_z;
            r1_qi <= i_quat_i;
            r1_qj <= i_quat_j;
            r1_qk <= i_quat_k;
            r1_qw <= i_quat_real;
        end
    end

    // Stage 2: scalar terms, dot product, cross product, norm
    logic signed [33:0] r_a, r_d;
    logic signed [32:0] r_cx, r_cy, r_cz;
    logic [DEN2_W-1:0]  r2_den2;
    logic               r2_zero;
    logic signed [VW-1:0] r2_vx, r2_vy, r2_vz, r2_qi, r2_qj, r2_qk, r2_qw;
    logic [32:0]        n_norm;

    assign n_norm = 33'(r_ww[31:0]) + 33'(r_ii[31:0]) + 33'(r_jj[31:0]) + 33'(r_kk[31:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a     <= 34'(r_ww) - 34'(r_ii) - 34'(r_jj) - 34'(r_kk);
            r_d     <= 34'(r_dx) + 34'(r_dy) + 34'(r_dz);
            r_cx    <= 33'(r_jvz) - 33'(r_kvy);
            r_cy    <= 33'(r_kvx) - 33'(r_ivz);
            r_cz    <= 33'(r_ivy) - 33'(r_jvx);
            r2_den2 <= {n_norm, 1'b0};
            r2_zero <= (n_norm == '0);
            r2_vx   <= r1_vx;
            r2_vy   <= r1_vy;
            r2_vz   <= r1_vz;
            r2_qi   <= r1_qi;
            r2_qj   <= r1_qj;
            r2_qk   <= r1_qk;
            r2_qw   <= r1_qw;
        end
    end

    // Stage 3: one wide multiply per term and lane
    logic signed [49:0] r_t1x, r_t1y, r_t1z, r_t2x, r_t2y, r_t2z;
    logic signed [48:0] r_t3x, r_t3y, r_t3z;
    logic [DEN2_W-1:0]  r3_den2;
    logic               r3_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1x   <= 50'(r_a * r2_vx);
            r_t1y   <= 50'(r_a * r2_vy);
            r_t1z   <= 50'(r_a * r2_vz);
            r_t2x   <= 50'(r_d * r2_qi);
            r_t2y   <= 50'(r_d * r2_qj);
            r_t2z   <= 50'(r_d * r2_qk);
            r_t3x   <= 49'(r_cx * r2_qw);
            r_t3y   <= 49'(r_cy * r2_qw);
            r_t3z   <= 49'(r_cz * r2_qw);
            r3_den2 <= r2_den2;
            r3_zero <= r2_zero;
        end
    end

    // Stage 4: combine terms, split into sign and magnitude
    logic signed [52:0] n_rx, n_ry, n_rz;
    logic [52:0]        n_ax, n_ay, n_az;
    t_prod              r_out;

    assign n_rx = 53'(r_t1x) + (53'(r_t2x) <<< 1) + (53'(r_t3x) <<< 1);
    assign n_ry = 53'(r_t1y) + (53'(r_t2y) <<< 1) + (53'(r_t3y) <<< 1);
    assign n_rz = 53'(r_t1z) + (53'(r_t2z) <<< 1) + (53'(r_t3z) <<< 1);
    assign n_ax = n_rx[52] ? 53'(-n_rx) : 53'(n_rx);
    assign n_ay = n_ry[52] ? 53'(-n_ry) : 53'(n_ry);
    assign n_az = n_rz[52] ? 53'(-n_rz) : 53'(n_rz);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.x.neg <= n_rx[52];
            r_out.x.mag <= n_ax[MAG_W-1:0];
            r_out.y.neg <= n_ry[52];
            r_out.y.mag <= n_ay[MAG_W-1:0];
            r_out.z.neg <= n_rz[52];
            r_out.z.mag <= n_az[MAG_W-1:0];
            r_out.den2  <= r3_den2;
            r_out.zero  <= r3_zero;
        end
    end

    assign o_prod = r_out;

endmodule

// ===== rtl/core/qvr_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with rounding
// to nearest and 16-bit saturation. Depends on qvr_pkg.
module qvr_divider
    import qvr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  t_lane                i_lane,
    input  logic [DEN2_W-1:0]    i_den2,
    output logic signed [VW-1:0] o_quot
);

    logic [NUM_W-1:0]  r_rem  [QB+1];
    logic [QB-1:0]     r_quo  [QB+1];
    logic [DEN2_W-1:0] r_dv   [QB+1];
    logic              r_neg  [QB+1];
    logic              r_ovf  [QB+1];
    logic [NUM_W-1:0]  n_num;
    logic [NUM_W-1:0]  n_top;
    logic signed [VW-1:0] r_res;

    // Rounded dividend 2*mag + n; the quotient over 2n then rounds half away
    assign n_num = {i_lane.mag, 1'b0} + NUM_W'(i_den2[DEN2_W-1:1]);
    assign n_top = NUM_W'(i_den2) << QB;

    // Stage 0: flag quotients that cannot fit the resolved bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_num;
            r_quo[0] <= '0;
            r_dv[0]  <= i_den2;
            r_neg[0] <= i_lane.neg;
            r_ovf[0] <= (n_num >= n_top);
        end
    end

    // One compare and subtract per stage, most significant bit first
    for (genvar s = 0; s < QB; s++) begin : g_bit
        localparam int K = QB - 1 - s;
        logic [NUM_W-1:0] w_trial;
        logic             w_ge;

        assign w_trial = NUM_W'(r_dv[s]) << K;
        assign w_ge    = (r_rem[s] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? (r_rem[s] - w_trial) : r_rem[s];
                r_quo[s+1] <= w_ge ? (r_quo[s] | (QB'(1) << K)) : r_quo[s];
                r_dv[s+1]  <= r_dv[s];
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    // Final stage: apply sign and saturate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[QB]) begin
                if (r_ovf[QB] || (r_quo[QB] > QB'(32768))) begin
                    r_res <= VW'(16'h8000);
                end else begin
                    r_res <= VW'(-$signed({1'b0, r_quo[QB]}));
                end
            end else begin
                if (r_ovf[QB] || (r_quo[QB] > QB'(32767))) begin
                    r_res <= VW'(16'h7FFF);
                end else begin
                    r_res <= r_quo[QB][VW-1:0];
                end
            end
        end
    end

    assign o_quot = r_res;

endmodule

// ===== rtl/core/quaternion_vector_rotate_unit.sv =====
// Top level of the quaternion vector rotation unit.
// Depends on qvr_pkg, qvr_product and qvr_divider.
//
// Usage:
//   Input channel  (i_in_valid / o_in_ready): one vector (Q8.8) and one
//   quaternion (Q2.14) per transaction; the quaternion need not be unit length.
//   Output channel (o_out_valid / i_out_ready): the rotated vector q*v*q^-1
//   in Q8.8, rounded to nearest and saturated, plus o_zero_quat_error, which
//   is set with a zero vector when the quaternion is all zero.
//   From input acceptance to output valid, data pass through four product
//   stages, one range-check stage, seventeen quotient-bit stages and one
//   saturation stage. Throughput is one transaction per cycle unless the
//   output stalls; the 17-bit restoring divider pipeline sets the depth.
//   The whole pipeline advances together: while the output holds a result
//   the receiver does not take, every stage holds and o_in_ready is low, so
//   nothing is lost or repeated. Bubbles advance whenever the output is empty.
//   Reset clears all valid bits; no result comes out until new input arrives.
module quaternion_vector_rotate_unit
    import qvr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [VW-1:0] i_vec_x,
    input  logic signed [VW-1:0] i_vec_y,
    input  logic signed [VW-1:0] i_vec_z,
    input  logic signed [VW-1:0] i_quat_i,
    input  logic signed [VW-1:0] i_quat_j,
    input  logic signed [VW-1:0] i_quat_k,
    input  logic signed [VW-1:0] i_quat_real,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [VW-1:0] o_rot_x,
    output logic signed [VW-1:0] o_rot_y,
    output logic signed [VW-1:0] o_rot_z,
    output logic                 o_zero_quat_error
);

    logic                 w_en;
    t_prod                w_prod;
    logic signed [VW-1:0] w_qx, w_qy, w_qz;
    logic                 r_vld  [LAT];
    logic                 r_zero [LAT_DIV];

    // Advance the pipeline unless a result waits at the output
    assign w_en       = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = w_en;

    qvr_product u_product (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .i_quat_i    (i_quat_i),
        .i_quat_j    (i_quat_j),
        .i_quat_k    (i_quat_k),
        .i_quat_real (i_quat_real),
        .o_prod      (w_prod)
    );

    qvr_divider u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_lane (w_prod.x),
        .i_den2 (w_prod.den2),
        .o_quot (w_qx)
    );

    qvr_divider u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_lane (w_prod.y),
        .i_den2 (w_prod.den2),
        .o_quot (w_qy)
    );

    qvr_divider u_div_z (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_lane (w_prod.z),
        .i_den2 (w_prod.den2),
        .o_quot (w_qz)
    );

    // Carry valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int s = 1; s < LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Delay the zero-norm flag across the dividers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero[0] <= w_prod.zero;
            for (int s = 1; s < LAT_DIV; s++) begin
                r_zero[s] <= r_zero[s-1];
            end
        end
    end

    // Drive zero on a zero quaternion
    assign o_out_valid       = r_vld[LAT-1];
    assign o_zero_quat_error = r_zero[LAT_DIV-1];
    assign o_rot_x           = r_zero[LAT_DIV-1] ? '0 : w_qx;
    assign o_rot_y           = r_zero[LAT_DIV-1] ? '0 : w_qy;
    assign o_rot_z           = r_zero[LAT_DIV-1] ? '0 : w_qz;

endmodule

// ===== rtl/core/qvr_checker.sv =====
// Port-level checker of the quaternion rotation unit, bound to the top level.
// Depends on qvr_pkg and quaternion_vector_rotate_unit_macros.svh.
`include "quaternion_vector_rotate_unit_macros.svh"

module qvr_checker
    import qvr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic signed [VW-1:0] i_vec_x,
    input logic signed [VW-1:0] i_vec_y,
    input logic signed [VW-1:0] i_vec_z,
    input logic signed [VW-1:0] i_quat_i,
    input logic signed [VW-1:0] i_quat_j,
    input logic signed [VW-1:0] i_quat_k,
    input logic signed [VW-1:0] i_quat_real,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic signed [VW-1:0] o_rot_x,
    input logic signed [VW-1:0] o_rot_y,
    input logic signed [VW-1:0] o_rot_z,
    input logic                 o_zero_quat_error
);

    // Hold a pending result until the receiver takes it
    `QVR_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "output dropped while stalled")

    // Zero quaternion yields a zero vector
    `QVR_ASSERT_IMP(a_zero_out, o_out_valid && o_zero_quat_error, (o_rot_x == '0) && (o_rot_y == '0) && (o_rot_z == '0), "nonzero result on zero quaternion")

    // Accept input whenever the output stage is empty or draining
    `QVR_ASSERT_IMP(a_ready, !o_out_valid || i_out_ready, o_in_ready, "input blocked without backpressure")

endmodule

bind quaternion_vector_rotate_unit qvr_checker u_qvr_checker (.*);
